/* hw/rtl/socket_pcb_wildcard_lookup_assert.svh */
// assertion macros for the connection table lookup checker
// expects clk and rst_n in the scope of the use; no other dependencies
`ifndef SOCKET_PCB_WILDCARD_LOOKUP_ASSERT_SVH
`define SOCKET_PCB_WILDCARD_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SPWL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SPWL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spwl_pkg.sv */
// shared types and constants for the connection table lookup
// no dependencies
`timescale 1ns / 1ps

package spwl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int WILD_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // best-so-far marker meaning nothing matched yet
    localparam logic [WILD_W-1:0] NO_MATCH_WILD = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] local_addr;
        logic [PORT_W-1:0] local_port;
        logic [ADDR_W-1:0] foreign_addr;
        logic [PORT_W-1:0] foreign_port;
    } entry_t;

    typedef struct packed {
        logic load;
        logic wr_en;
        logic clr_en;
        logic score;
        logic out_load;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

/* hw/rtl/spwl_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module spwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/spwl_ctrl.sv */
// controller for the connection table lookup: handshakes, scan sequencing
// depends on spwl_pkg
`timescale 1ns / 1ps

module spwl_ctrl #(
    parameter int TABLE_DEPTH = spwl_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [spwl_pkg::OP_W-1:0] op,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      exact_hit,
    output spwl_pkg::dp_cmd_t         cmd,
    output logic [IDX_W-1:0]          rd_addr
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    spwl_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_ready = (state_reg == spwl_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load     = accept;
        cmd.wr_en    = accept && (op == spwl_pkg::OP_WRITE);
        cmd.clr_en   = accept && (op == spwl_pkg::OP_CLEAR);
        cmd.score    = (state_reg == spwl_pkg::ST_SCAN) || (state_reg == spwl_pkg::ST_LAST);
        cmd.out_load = (state_reg == spwl_pkg::ST_FINISH) && out_free;
        // entry 0 is read in the accept cycle, the rest during the scan
        rd_addr      = (state_reg == spwl_pkg::ST_SCAN) ? idx_reg : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            spwl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == spwl_pkg::OP_LOOKUP)
                    begin
                        state_next = spwl_pkg::ST_SCAN;
                        idx_next   = IDX_W'(1);
                    end
                    else
                    begin
                        state_next = spwl_pkg::ST_FINISH;
                    end
                end
            end
            spwl_pkg::ST_SCAN:
            begin
                if (exact_hit)
                begin
                    state_next = spwl_pkg::ST_FINISH;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = spwl_pkg::ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            spwl_pkg::ST_LAST:
            begin
                state_next = spwl_pkg::ST_FINISH;
            end
            spwl_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = spwl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spwl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spwl_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/spwl_dp.sv */
// datapath for the connection table lookup: entry store, scoring, best match
// depends on spwl_pkg and spwl_ram
`timescale 1ns / 1ps

module spwl_dp #(
    parameter int TABLE_DEPTH = spwl_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spwl_pkg::dp_cmd_t           cmd,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic                        exact_hit,
    input  logic [spwl_pkg::SLOT_W-1:0] slot,
    input  logic [spwl_pkg::ADDR_W-1:0] local_addr,
    input  logic [spwl_pkg::PORT_W-1:0] local_port,
    input  logic [spwl_pkg::ADDR_W-1:0] foreign_addr,
    input  logic [spwl_pkg::PORT_W-1:0] foreign_port,
    input  logic                        allow_wildcard,
    output logic                        found,
    output logic [spwl_pkg::SLOT_W-1:0] match_slot,
    output logic [spwl_pkg::WILD_W-1:0] wildcard_count
);

    spwl_pkg::entry_t query_reg;
    spwl_pkg::entry_t in_entry;
    spwl_pkg::entry_t rd_entry;
    logic             allow_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    logic [spwl_pkg::WILD_W-1:0] best_wild_reg;
    logic [IDX_W-1:0]            best_slot_reg;

    logic                        found_reg;
    logic [spwl_pkg::SLOT_W-1:0] match_slot_reg;
    logic [spwl_pkg::WILD_W-1:0] wild_out_reg;

    logic             slot_ok;
    logic [IDX_W-1:0] wr_idx;
    logic             ent_la_set, q_la_set, ent_fa_set, q_fa_set;
    logic             local_bad, foreign_bad, port_bad;
    logic [spwl_pkg::WILD_W-1:0] wild;
    logic             hit;
    logic             better;
    logic             best_found;

    assign in_entry = '{local_addr:   local_addr,
                        local_port:   local_port,
                        foreign_addr: foreign_addr,
                        foreign_port: foreign_port};

    // slots past the table are dropped
    assign slot_ok = (int'(slot) < TABLE_DEPTH);
    assign wr_idx  = IDX_W'(slot);

    spwl_ram #(
        .WIDTH ($bits(spwl_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.wr_en && slot_ok),
        .waddr (wr_idx),
        .wdata (in_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // wildcard score of the entry coming out of the ram
    always_comb
    begin
        ent_la_set  = (rd_entry.local_addr != '0);
        q_la_set    = (query_reg.local_addr != '0);
        ent_fa_set  = (rd_entry.foreign_addr != '0);
        q_fa_set    = (query_reg.foreign_addr != '0);
        port_bad    = (rd_entry.local_port != query_reg.local_port);
        local_bad   = ent_la_set && q_la_set && (rd_entry.local_addr != query_reg.local_addr);
        foreign_bad = ent_fa_set && q_fa_set &&
                      ((rd_entry.foreign_addr != query_reg.foreign_addr) ||
                       (rd_entry.foreign_port != query_reg.foreign_port));
        wild        = {1'b0, ent_la_set ^ q_la_set} + {1'b0, ent_fa_set ^ q_fa_set};
        hit         = rd_valid_reg && !port_bad && !local_bad && !foreign_bad &&
                      ((wild == '0) || allow_reg);
        // strict compare keeps the lowest slot on a tie
        better      = cmd.score && hit && (wild < best_wild_reg);
        exact_hit   = cmd.score && hit && (wild == '0);
        best_found  = (best_wild_reg != spwl_pkg::NO_MATCH_WILD);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            query_reg <= in_entry;
            allow_reg <= allow_wildcard;
        end
        rd_idx_reg <= rd_addr;
        if (cmd.out_load)
        begin
            found_reg      <= best_found;
            match_slot_reg <= best_found ? spwl_pkg::SLOT_W'(best_slot_reg) : '0;
            wild_out_reg   <= best_found ? best_wild_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            best_wild_reg <= spwl_pkg::NO_MATCH_WILD;
            best_slot_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en && slot_ok)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.clr_en && slot_ok)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            if (cmd.load)
            begin
                best_wild_reg <= spwl_pkg::NO_MATCH_WILD;
                best_slot_reg <= '0;
            end
            else if (better)
            begin
                best_wild_reg <= wild;
                best_slot_reg <= rd_idx_reg;
            end
        end
    end

    assign found          = found_reg;
    assign match_slot     = match_slot_reg;
    assign wildcard_count = wild_out_reg;

endmodule

/* hw/rtl/socket_pcb_wildcard_lookup.sv */
// top level of the connection table with wildcard lookup
// depends on spwl_pkg, spwl_ctrl, spwl_dp (and spwl_ram beneath it)
//
//   channel  handshake             payload
//   in       in_valid / in_ready   op slot local_addr local_port foreign_addr
//                                  foreign_port allow_wildcard
//   out      out_valid / out_ready found match_slot wildcard_count
//
// a write, clear or unused op goes from acceptance straight to the finish state
// a lookup reads and scores the entry ram one entry per cycle, in slot order,
// and stops the scan early on an exact match
// one transaction is in work at a time; in_ready rises again while the output
// register still holds the result, and a stalled output holds the finish state
// reset clears all valid bits at once, no clearing pass
`timescale 1ns / 1ps

module socket_pcb_wildcard_lookup #(
    parameter int TABLE_DEPTH = spwl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [spwl_pkg::OP_W-1:0]   op,
    input  logic [spwl_pkg::SLOT_W-1:0] slot,
    input  logic [spwl_pkg::ADDR_W-1:0] local_addr,
    input  logic [spwl_pkg::PORT_W-1:0] local_port,
    input  logic [spwl_pkg::ADDR_W-1:0] foreign_addr,
    input  logic [spwl_pkg::PORT_W-1:0] foreign_port,
    input  logic                        allow_wildcard,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [spwl_pkg::SLOT_W-1:0] match_slot,
    output logic [spwl_pkg::WILD_W-1:0] wildcard_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    spwl_pkg::dp_cmd_t cmd;
    logic [IDX_W-1:0]  rd_addr;
    logic              exact_hit;

    spwl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .exact_hit (exact_hit),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    spwl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .exact_hit      (exact_hit),
        .slot           (slot),
        .local_addr     (local_addr),
        .local_port     (local_port),
        .foreign_addr   (foreign_addr),
        .foreign_port   (foreign_port),
        .allow_wildcard (allow_wildcard),
        .found          (found),
        .match_slot     (match_slot),
        .wildcard_count (wildcard_count)
    );

endmodule

/* hw/rtl/spwl_chk.sv */
// port-level checker for the connection table lookup, bound to the top level
// depends on spwl_pkg and socket_pcb_wildcard_lookup_assert.svh
`timescale 1ns / 1ps
`include "socket_pcb_wildcard_lookup_assert.svh"

module spwl_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [spwl_pkg::SLOT_W-1:0] match_slot,
    input logic [spwl_pkg::WILD_W-1:0] wildcard_count
);

    localparam int RES_W = 1 + spwl_pkg::SLOT_W + spwl_pkg::WILD_W;

    logic             in_take;
    logic             out_stall;
    logic             out_miss;
    logic             out_hit;
    logic             res_zero;
    logic             wild_ok;
    logic [RES_W-1:0] res_word;

    assign in_take   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_miss  = out_valid && !found;
    assign out_hit   = out_valid && found;
    assign res_zero  = (match_slot == '0) && (wildcard_count == '0);
    assign wild_ok   = (wildcard_count != spwl_pkg::NO_MATCH_WILD);
    assign res_word  = {found, match_slot, wildcard_count};

    // a stalled result keeps its value
    `SPWL_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(res_word), "result not held")

    // a miss or a table update answers with all zeros
    `SPWL_ASSERT_IMP(a_miss_zero, out_miss, res_zero, "non-zero fields without a match")

    // at most two wildcard sides in a match
    `SPWL_ASSERT_IMP(a_wild_range, out_hit, wild_ok, "wildcard count out of range")

    // one transaction in work at a time
    `SPWL_ASSERT_NXT(a_busy_after_accept, in_take, !in_ready, "input taken while busy")

endmodule

bind socket_pcb_wildcard_lookup spwl_chk u_spwl_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .match_slot     (match_slot),
    .wildcard_count (wildcard_count)
);

/* sim/tb_socket_pcb_wildcard_lookup.sv */
// testbench for the connection table with wildcard lookup: directed and random
// write, clear, lookup and no-op traffic checked against an in-bench table predictor
// depends on spwl_pkg and socket_pcb_wildcard_lookup
`timescale 1ns / 1ps

module tb_socket_pcb_wildcard_lookup;

    import spwl_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int N_RANDOM     = 1430;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;

    // op code the block treats as a no-op
    localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] local_addr;
        logic [PORT_W-1:0] local_port;
        logic [ADDR_W-1:0] foreign_addr;
        logic [PORT_W-1:0] foreign_port;
        logic              allow_wildcard;
        logic              drain_first;
    } pcb_req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_slot;
        logic [WILD_W-1:0] wildcard_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [ADDR_W-1:0] local_addr = '0;
    logic [PORT_W-1:0] local_port = '0;
    logic [ADDR_W-1:0] foreign_addr = '0;
    logic [PORT_W-1:0] foreign_port = '0;
    logic              allow_wildcard = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    logic [SLOT_W-1:0] match_slot;
    logic [WILD_W-1:0] wildcard_count;

    socket_pcb_wildcard_lookup u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .slot           (slot),
        .local_addr     (local_addr),
        .local_port     (local_port),
        .foreign_addr   (foreign_addr),
        .foreign_port   (foreign_port),
        .allow_wildcard (allow_wildcard),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_slot     (match_slot),
        .wildcard_count (wildcard_count)
    );

    always #2 clk = ~clk;

    pcb_req_t req_queue[$];
    answer_t  answer_q[$];

    // predictor copy of the connection table
    logic   tbl_valid [DEPTH];
    entry_t tbl_entry [DEPTH];

    pcb_req_t cur_req;
    int       n_total = 0;
    int       n_issued = 0;
    int       n_answered = 0;
    int       errors = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    int       idle_pct = 0;
    logic     calm = 1'b0;
    int       cycles = 0;
    int       op_seen [4];
    int       hits [3];
    int       misses = 0;

    function automatic answer_t lookup_predict(pcb_req_t r);
        answer_t           a;
        logic [WILD_W-1:0] best;
        logic [WILD_W-1:0] w;
        logic              rej;
        a = '0;
        best = NO_MATCH_WILD;
        case (r.op)
            OP_WRITE:
            begin
                tbl_valid[r.slot] = 1'b1;
                tbl_entry[r.slot] = '{r.local_addr, r.local_port,
                                      r.foreign_addr, r.foreign_port};
            end
            OP_CLEAR:
                tbl_valid[r.slot] = 1'b0;
            OP_LOOKUP:
            begin
                // an exact hit (best == 0) ends the scan; strict compare keeps lowest slot
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (best != 0 && tbl_valid[i] &&
                        tbl_entry[i].local_port == r.local_port)
                    begin
                        w = '0;
                        rej = 1'b0;
                        if (tbl_entry[i].local_addr != 0)
                        begin
                            if (r.local_addr == 0)
                                w++;
                            else if (tbl_entry[i].local_addr != r.local_addr)
                                rej = 1'b1;
                        end
                        else if (r.local_addr != 0)
                            w++;
                        if (tbl_entry[i].foreign_addr != 0)
                        begin
                            if (r.foreign_addr == 0)
                                w++;
                            else if (tbl_entry[i].foreign_addr != r.foreign_addr ||
                                     tbl_entry[i].foreign_port != r.foreign_port)
                                rej = 1'b1;
                        end
                        else if (r.foreign_addr != 0)
                            w++;
                        if (w != 0 && !r.allow_wildcard)
                            rej = 1'b1;
                        if (!rej && w < best)
                        begin
                            best = w;
                            a.found = 1'b1;
                            a.match_slot = i[SLOT_W-1:0];
                            a.wildcard_count = w;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic add_req(input logic [OP_W-1:0] o, input int s,
                           input logic [ADDR_W-1:0] la, input logic [PORT_W-1:0] lp,
                           input logic [ADDR_W-1:0] fa, input logic [PORT_W-1:0] fp,
                           input logic aw);
        pcb_req_t r;
        r = '{o, s[SLOT_W-1:0], la, lp, fa, fp, aw, 1'b0};
        req_queue.push_back(r);
    endtask

    // mostly addresses and ports from small pools so that lookups hit often
    function automatic pcb_req_t random_req();
        pcb_req_t          r;
        int                pick;
        logic [ADDR_W-1:0] lpool [4];
        logic [ADDR_W-1:0] fpool [3];
        logic [PORT_W-1:0] ppool [4];
        logic [PORT_W-1:0] fppool [2];
        lpool  = '{32'h0, 32'h0A00_0001, 32'h0A00_0002, 32'hFFFF_FFFF};
        fpool  = '{32'h0, 32'hC0A8_0001, 32'hC0A8_0002};
        ppool  = '{16'd80, 16'd443, 16'd8080, 16'hFFFF};
        fppool = '{16'd1024, 16'd5000};
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.op = OP_WRITE;
        else if (pick < 40)
            r.op = OP_CLEAR;
        else if (pick < 95)
            r.op = OP_LOOKUP;
        else
            r.op = OP_IDLE;
        r.slot = SLOT_W'($urandom_range(0, DEPTH - 1));
        r.allow_wildcard = 1'($urandom_range(0, 1));
        r.drain_first = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            r.local_addr   = $urandom();
            r.local_port   = PORT_W'($urandom());
            r.foreign_addr = $urandom();
            r.foreign_port = PORT_W'($urandom());
        end
        else
        begin
            r.local_addr   = lpool[2'($urandom_range(0, 3))];
            r.local_port   = ppool[2'($urandom_range(0, 3))];
            r.foreign_addr = fpool[2'($urandom_range(0, 2))];
            r.foreign_port = fppool[1'($urandom_range(0, 1))];
        end
        return r;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        pcb_req_t nxt;
        logic     taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            idle_pct <= 0;
            calm <= 1'b0;
        end
        else
        begin
            taken = in_valid && in_ready;
            calm <= (req_queue.size() < CALM_TAIL);
            if (taken)
            begin
                answer_q.push_back(lookup_predict(cur_req));
                op_seen[cur_req.op]++;
                n_issued <= n_issued + 1;
                if ((n_issued + 1) % 100 == 0)
                    idle_pct <= $urandom_range(0, 3) * 15;
            end
            if (!in_valid || taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (req_queue[0].drain_first && (taken || n_issued != n_answered))
                    in_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left <= $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = req_queue.pop_front();
                    cur_req <= nxt;
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    slot <= nxt.slot;
                    local_addr <= nxt.local_addr;
                    local_port <= nxt.local_port;
                    foreign_addr <= nxt.foreign_addr;
                    foreign_port <= nxt.foreign_port;
                    allow_wildcard <= nxt.allow_wildcard;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_issued == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : check_answers
        answer_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_answered <= n_answered + 1;
                if (answer_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: found %0d slot %0d",
                           found, match_slot);
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        errors++;
                    end
                    if (match_slot !== want.match_slot)
                    begin
                        $error("match_slot: expected %0d, got %0d",
                               want.match_slot, match_slot);
                        errors++;
                    end
                    if (wildcard_count !== want.wildcard_count)
                    begin
                        $error("wildcard_count: expected %0d, got %0d",
                               want.wildcard_count, wildcard_count);
                        errors++;
                    end
                    if (want.found)
                        hits[want.wildcard_count]++;
                    else
                        misses++;
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left <= $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        pcb_req_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_entry[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            op_seen[i] = 0;
        for (int i = 0; i < 3; i++)
            hits[i] = 0;

        // directed: empty table, no-op, wildcard levels, ties, extremes, clears
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'h0, 16'd0, 1'b1);
        add_req(OP_IDLE, 7, 32'hDEAD_BEEF, 16'd80, 32'h1234_5678, 16'd9, 1'b1);
        add_req(OP_WRITE, 0, 32'h0, 16'd80, 32'h0, 16'd0, 1'b0);
        add_req(OP_WRITE, 5, 32'h0A00_0001, 16'd80, 32'h0, 16'd0, 1'b0);
        add_req(OP_WRITE, 9, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b0);
        add_req(OP_WRITE, 15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b1);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b0);
        // foreign port differs: falls back to the best wildcard entry, or misses without wildcards
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd999, 1'b1);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd999, 1'b0);
        add_req(OP_LOOKUP, 3, 32'h0, 16'd80, 32'h0, 16'd0, 1'b0);
        add_req(OP_LOOKUP, 0, 32'h0B00_0001, 16'd80, 32'h0, 16'd0, 1'b1);
        add_req(OP_LOOKUP, 0, 32'h0B00_0001, 16'd80, 32'hC0A8_0002, 16'd7, 1'b1);
        add_req(OP_WRITE, 3, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b1);
        add_req(OP_LOOKUP, 15, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b0);
        add_req(OP_LOOKUP, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd81, 32'h0, 16'd0, 1'b1);
        add_req(OP_CLEAR, 3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b0);
        add_req(OP_CLEAR, 15, 32'h0, 16'd0, 32'h0, 16'd0, 1'b0);
        add_req(OP_LOOKUP, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_req(OP_IDLE, 9, 32'h0, 16'hFFFF, 32'h0, 16'hFFFF, 1'b0);
        add_req(OP_LOOKUP, 0, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234, 1'b1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = random_req();
            // sender waits for the block to drain before these
            if (i == 0 || i == 800)
                r.drain_first = 1'b1;
            req_queue.push_back(r);
        end
        n_total = req_queue.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_issued == n_total && n_answered == n_total);
        repeat (40) @(posedge clk);
        if (answer_q.size() != 0)
        begin
            $error("%0d expected results never arrived", answer_q.size());
            errors++;
        end
        $display("covered %0d transactions: %0d writes, %0d clears, %0d lookups, %0d no-ops",
                 n_issued, op_seen[OP_WRITE], op_seen[OP_CLEAR], op_seen[OP_LOOKUP],
                 op_seen[OP_IDLE]);
        $display("lookup hits by wildcard count 0/1/2: %0d/%0d/%0d, misses: %0d",
                 hits[0], hits[1], hits[2], misses);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
